// File: rtl/ssfg_pkg.sv
// ----------------------------------------------------------------------------
// ssfg_pkg
// Shared constants, types and the digit code table of the seven-segment
// frame generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfg_pkg;

   // Display geometry
   localparam int DIGIT_COUNT = 4;
   localparam int SEP_DIGIT   = 2;
   localparam bit SEP_PRESENT = (DIGIT_COUNT > SEP_DIGIT);
   localparam int BYTE_COUNT  = DIGIT_COUNT + 2;

   localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int BYTE_CNT_W  = $clog2(BYTE_COUNT);

   // Field widths
   localparam int NUMBER_W = 14;
   localparam int LEVEL_W  = 4;
   localparam int BYTE_W   = 8;
   localparam int DIGIT_W  = 4;

   // Divide by ten: multiply by reciprocal, exact for values below 43690
   localparam int                RECIP_W      = 16;
   localparam logic [RECIP_W-1:0] RECIP_DIV10 = 16'd52429;
   localparam int                RECIP_SHIFT  = 19;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request codes
   localparam logic REQ_NUMBER = 1'b0;
   localparam logic REQ_BRIGHT = 1'b1;

   // Controller command bytes
   localparam logic [BYTE_W-1:0] CMD_DATA_WRITE  = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_ADDR_FIRST  = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_BRIGHT_BASE = 8'h87;
   localparam logic [BYTE_W-1:0] SEP_MASK        = 8'h80;

   // One classified request, ready for the back end
   typedef struct packed {
      logic                               bright;
      logic [BYTE_W-1:0]                  ctrl_byte;
      logic [DIGIT_COUNT-1:0][BYTE_W-1:0] codes;
   } ssfg_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ssfg_q_status_type;

   typedef enum logic [1:0] {
      FRONT_EMPTY,
      FRONT_SPLIT,
      FRONT_READY
   } front_state_type;

   function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
      logic [BYTE_W-1:0] code;
      unique case (digit)
         4'd0:    code = 8'h3f;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5b;
         4'd3:    code = 8'h4f;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6d;
         4'd6:    code = 8'h7d;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7f;
         4'd9:    code = 8'h6f;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ssfg_if.sv
// ----------------------------------------------------------------------------
// ssfg_if
// Valid/ready channels of the frame generator: request in, bus byte out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssfg_req_if;
   import ssfg_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [NUMBER_W-1:0] number;
   logic                separator_on;
   logic [LEVEL_W-1:0]  brightness_level;

   modport source (output valid, req_type, number, separator_on, brightness_level,
                   input ready);
   modport sink   (input valid, req_type, number, separator_on, brightness_level,
                   output ready);
endinterface

interface ssfg_rsp_if;
   import ssfg_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] bus_byte;
   logic              frame_start;
   logic              frame_end;
   logic              last;

   modport source (output valid, bus_byte, frame_start, frame_end, last,
                   input ready);
   modport sink   (input valid, bus_byte, frame_start, frame_end, last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/ssfg_front.sv
// ----------------------------------------------------------------------------
// ssfg_front
// Accepts requests, splits numbers into digit codes one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfg_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ssfg_req_if.sink                         req_chan,
   input  wire ssfg_pkg::ssfg_q_status_type q_status,
   output logic                             push_valid,
   output ssfg_pkg::ssfg_rec_type           push_rec
);
   import ssfg_pkg::*;

   front_state_type                    state_ff, state_in;
   logic [NUMBER_W-1:0]                val_ff, val_in;
   logic [DIGIT_IDX_W-1:0]             digit_cnt_ff, digit_cnt_in;
   logic                               sep_ff, sep_in;
   ssfg_rec_type                       rec_ff, rec_in;

   logic [NUMBER_W+RECIP_W-1:0] prod;
   logic [NUMBER_W-1:0]         quot;
   logic [NUMBER_W+2:0]         ten_q;
   logic [NUMBER_W+2:0]         rem_full;
   logic [BYTE_W-1:0]           code;
   logic                        accept;
   logic                        push;

   // Digit split: quotient by reciprocal, remainder by shift-add
   assign prod     = (NUMBER_W+RECIP_W)'(val_ff) * (NUMBER_W+RECIP_W)'(RECIP_DIV10);
   assign quot     = NUMBER_W'(prod >> RECIP_SHIFT);
   assign ten_q    = {quot, 3'b000} + (NUMBER_W+3)'({quot, 1'b0});
   assign rem_full = (NUMBER_W+3)'(val_ff) - ten_q;

   always_comb begin
      code = seg_code(rem_full[DIGIT_W-1:0]);
      if (SEP_PRESENT && sep_ff && (digit_cnt_ff == DIGIT_IDX_W'(SEP_DIGIT))) begin
         code = code | SEP_MASK;
      end
   end

   assign push           = (state_ff == FRONT_READY) && !q_status.full;
   assign req_chan.ready = (state_ff == FRONT_EMPTY) || push;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = push;
   assign push_rec       = rec_ff;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      digit_cnt_in = digit_cnt_ff;
      sep_in       = sep_ff;
      rec_in       = rec_ff;
      unique case (state_ff)
         FRONT_EMPTY, FRONT_READY: begin
            if (push) begin
               state_in = FRONT_EMPTY;
            end
            if (accept) begin
               rec_in.bright    = (req_chan.req_type == REQ_BRIGHT);
               rec_in.ctrl_byte = CMD_BRIGHT_BASE + BYTE_W'(req_chan.brightness_level);
               val_in           = req_chan.number;
               sep_in           = req_chan.separator_on;
               digit_cnt_in     = '0;
               state_in         = (req_chan.req_type == REQ_BRIGHT) ? FRONT_READY
                                                                    : FRONT_SPLIT;
            end
         end
         FRONT_SPLIT: begin
            // shift the new code in at the top; ones end at index 0
            for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
               rec_in.codes[i] = rec_ff.codes[i+1];
            end
            rec_in.codes[DIGIT_COUNT-1] = code;
            val_in       = quot;
            digit_cnt_in = digit_cnt_ff + 1'b1;
            if (digit_cnt_ff == DIGIT_IDX_W'(DIGIT_COUNT - 1)) begin
               state_in = FRONT_READY;
            end
         end
         default: begin
            state_in = FRONT_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      digit_cnt_ff <= digit_cnt_in;
      sep_ff       <= sep_in;
      rec_ff       <= rec_in;
   end

endmodule

`default_nettype wire

// File: rtl/ssfg_queue.sv
// ----------------------------------------------------------------------------
// ssfg_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfg_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  wire ssfg_pkg::ssfg_rec_type push_rec,
   input  wire logic                   pop,
   output ssfg_pkg::ssfg_q_status_type q_status,
   output ssfg_pkg::ssfg_rec_type      head_rec
);
   import ssfg_pkg::*;

   ssfg_rec_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_rec       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ssfg_back.sv
// ----------------------------------------------------------------------------
// ssfg_back
// Walks the queue head byte by byte and drives the registered bus output.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfg_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ssfg_pkg::ssfg_q_status_type q_status,
   input  wire ssfg_pkg::ssfg_rec_type      head_rec,
   output logic                             pop,
   ssfg_rsp_if.source                       rsp_chan
);
   import ssfg_pkg::*;

   localparam logic [BYTE_CNT_W-1:0] BYTE_DATA_CMD = BYTE_CNT_W'(0);
   localparam logic [BYTE_CNT_W-1:0] BYTE_ADDR_CMD = BYTE_CNT_W'(1);
   localparam logic [BYTE_CNT_W-1:0] BYTE_FINAL    = BYTE_CNT_W'(BYTE_COUNT - 1);

   logic [BYTE_CNT_W-1:0]  byte_cnt_ff, byte_cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      bus_byte_ff;
   logic                   frame_start_ff;
   logic                   frame_end_ff;
   logic                   last_ff;

   logic                   advance;
   logic                   issue;
   logic                   byte_last;
   logic [DIGIT_IDX_W-1:0] code_idx;
   logic [BYTE_W-1:0]      next_byte;
   logic                   next_start;
   logic                   next_end;

   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign issue     = advance && !q_status.empty;
   assign byte_last = head_rec.bright || (byte_cnt_ff == BYTE_FINAL);
   assign pop       = issue && byte_last;
   assign code_idx  = DIGIT_IDX_W'(BYTE_FINAL - byte_cnt_ff);

   always_comb begin
      if (head_rec.bright) begin
         next_byte  = head_rec.ctrl_byte;
         next_start = 1'b1;
         next_end   = 1'b1;
      end else if (byte_cnt_ff == BYTE_DATA_CMD) begin
         next_byte  = CMD_DATA_WRITE;
         next_start = 1'b1;
         next_end   = 1'b1;
      end else if (byte_cnt_ff == BYTE_ADDR_CMD) begin
         next_byte  = CMD_ADDR_FIRST;
         next_start = 1'b1;
         next_end   = 1'b0;
      end else begin
         next_byte  = head_rec.codes[code_idx];
         next_start = 1'b0;
         next_end   = byte_last;
      end
   end

   always_comb begin
      byte_cnt_in  = byte_cnt_ff;
      out_valid_in = out_valid_ff;
      if (issue) begin
         byte_cnt_in  = byte_last ? '0 : byte_cnt_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         byte_cnt_ff  <= byte_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         bus_byte_ff    <= next_byte;
         frame_start_ff <= next_start;
         frame_end_ff   <= next_end;
         last_ff        <= byte_last;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.bus_byte    = bus_byte_ff;
   assign rsp_chan.frame_start = frame_start_ff;
   assign rsp_chan.frame_end   = frame_end_ff;
   assign rsp_chan.last        = last_ff;

endmodule

`default_nettype wire

// File: rtl/seven_segment_frame_generator.sv
// ----------------------------------------------------------------------------
// seven_segment_frame_generator
// Turns number and brightness requests into byte frames for a two-wire
// four-digit seven-segment display controller.
// ----------------------------------------------------------------------------
// Flow: a request is held in the front record register, pushed into the queue
//   and its bytes issue from the output register; numbers are split first.
// Throughput: one byte per cycle at the output register unless the output stalls;
//   a number request gives DIGIT_COUNT + 2 bytes (6) and a brightness request 1;
//   the front splits one digit per cycle.
// Reset: synchronous, active high; clears the front state, queue pointers and
//   count, the back byte counter and output valid. No clearing pass.
`default_nettype none

module seven_segment_frame_generator (
   input  wire logic  clock,
   input  wire logic  reset,
   ssfg_req_if.sink   req_chan,
   ssfg_rsp_if.source rsp_chan
);
   import ssfg_pkg::*;

   // Front to queue
   logic              push_valid;
   ssfg_rec_type      push_rec;

   // Queue to back
   ssfg_q_status_type q_status;
   ssfg_rec_type      head_rec;
   logic              pop;

   // Front: transfer requests, classify, split the number into segment codes
   // (ones first) and hold the finished record until the queue takes it.
   ssfg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   // Queue: decouple digit splitting from byte emission so a new request
   // can be split while the previous one is still going out.
   ssfg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .pop        (pop),
      .q_status   (q_status),
      .head_rec   (head_rec)
   );

   // Back: emit data command, address, then digits most significant first (a
   // brightness request emits its control byte alone); drop the record from the queue with its final byte.
   ssfg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_rec (head_rec),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: rtl/ssfg_checker.sv
// ----------------------------------------------------------------------------
// ssfg_checker
// Port-level checks of the frame generator output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfg_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [ssfg_pkg::BYTE_W-1:0] rsp_bus_byte,
   input wire logic                      rsp_frame_start,
   input wire logic                      rsp_frame_end,
   input wire logic                      rsp_last
);
   import ssfg_pkg::*;

   // Stalled byte holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_byte)
         && $stable(rsp_last) && $stable(rsp_frame_end))
      else $error("stalled output byte changed");

   // Nothing valid right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // Final byte of a request closes its frame
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_end)
      else $error("last byte without stop");

   // An open frame start is always the address command
   a_addr_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_start && !rsp_frame_end |-> rsp_bus_byte == CMD_ADDR_FIRST)
      else $error("open frame does not start with address");

endmodule

bind seven_segment_frame_generator ssfg_checker u_ssfg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_bus_byte    (rsp_chan.bus_byte),
   .rsp_frame_start (rsp_chan.frame_start),
   .rsp_frame_end   (rsp_chan.frame_end),
   .rsp_last        (rsp_chan.last)
);

`default_nettype wire
